>>> rtl/pmd_pkg.sv
// ----------------------------------------------------------------------------
// pmd_pkg
// Shared types and constants for the PS/2 mouse packet decoder.
// ----------------------------------------------------------------------------
package pmd_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 2;
	localparam int unsigned NUM_BUTTONS = 3;
	localparam int unsigned OUT_TDATA_W = 24;

	localparam logic [1:0] KIND_MOVE    = 2'd0;
	localparam logic [1:0] KIND_PRESS   = 2'd1;
	localparam logic [1:0] KIND_RELEASE = 2'd2;

	localparam logic [1:0] LAST_POS = 2'd2;

	typedef struct packed {
		logic                   mv;
		logic [7:0]             dx;
		logic [7:0]             dy;
		logic [NUM_BUTTONS-1:0] chg;
		logic [NUM_BUTTONS-1:0] old;
	} pmd_pkt_t;

endpackage

>>> rtl/pmd_front.sv
// ----------------------------------------------------------------------------
// pmd_front
// Byte intake: filters aux bytes, assembles packets, tracks buttons.
// ----------------------------------------------------------------------------
module pmd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // data_byte
	input  logic              s_tuser,   // aux_data_ready
	input  logic              q_full,
	output logic              push,
	output pmd_pkg::pmd_pkt_t push_pkt
);
	import pmd_pkg::*;

	logic [1:0]             pos_q;
	logic [7:0]             b0_q;
	logic [7:0]             b1_q;
	logic [NUM_BUTTONS-1:0] btn_q;
	logic                   take;
	logic                   done;
	logic [NUM_BUTTONS-1:0] btn_new;

	assign s_tready = !q_full;
	assign take     = s_tvalid && s_tready && s_tuser;
	assign done     = take && (pos_q >= LAST_POS);
	assign btn_new  = b0_q[NUM_BUTTONS-1:0];

	always_comb begin
		push_pkt.mv  = (b1_q != 8'd0) || (s_tdata != 8'd0);
		push_pkt.dx  = b1_q;
		push_pkt.dy  = s_tdata;
		push_pkt.chg = btn_new ^ btn_q;
		push_pkt.old = btn_q;
	end

	assign push = done && (push_pkt.mv || (push_pkt.chg != '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 2'd0;
			btn_q <= '0;
		end else if (take) begin
			if (done) begin
				pos_q <= 2'd0;
				btn_q <= btn_new;
			end else begin
				pos_q <= pos_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && (pos_q == 2'd0))
			b0_q <= s_tdata;
		if (take && (pos_q == 2'd1))
			b1_q <= s_tdata;
	end

endmodule

>>> rtl/pmd_fifo.sv
// ----------------------------------------------------------------------------
// pmd_fifo
// Short packet queue between intake and event emitter.
// ----------------------------------------------------------------------------
module pmd_fifo #(
	parameter int unsigned DEPTH = pmd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pmd_pkg::pmd_pkt_t push_pkt,
	output logic              full,
	input  logic              pop,
	output logic              not_empty,
	output pmd_pkg::pmd_pkt_t head
);
	import pmd_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	pmd_pkt_t      mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_pop;

	assign full      = (cnt_q == FULL_CNT);
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_q];
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == LAST_IDX) ? '0 : wr_q + PW'(1);
			if (do_pop)
				rd_q <= (rd_q == LAST_IDX) ? '0 : rd_q + PW'(1);
			if (push && !do_pop)
				cnt_q <= cnt_q + CW'(1);
			else if (!push && do_pop)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_pkt;
	end

endmodule

>>> rtl/pmd_back.sv
// ----------------------------------------------------------------------------
// pmd_back
// Event emitter: expands one packet record into move and button events.
// ----------------------------------------------------------------------------
module pmd_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               not_empty,
	input  pmd_pkg::pmd_pkt_t                  head,
	output logic                               pop,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [pmd_pkg::OUT_TDATA_W-1:0]    m_tdata,  // move_x, move_y, button_number
	output logic [1:0]                         m_tuser,  // event_kind
	output logic                               m_tlast   // last_event
);
	import pmd_pkg::*;

	pmd_pkt_t               work_q;
	logic [NUM_BUTTONS:0]   mask_q;     // bit 0 move, bits above buttons
	logic [NUM_BUTTONS:0]   sel;
	logic [NUM_BUTTONS:0]   rest;
	logic                   emit;
	logic                   last;
	logic [1:0]             kind;
	logic [7:0]             ox;
	logic [7:0]             oy;
	logic [1:0]             bnum;

	logic                   ov_q;
	logic [1:0]             okind_q;
	logic [7:0]             ox_q;
	logic [7:0]             oy_q;
	logic [1:0]             obn_q;
	logic                   olast_q;

	always_comb begin
		sel  = '0;
		kind = KIND_MOVE;
		ox   = 8'd0;
		oy   = 8'd0;
		bnum = 2'd0;
		priority if (mask_q[0]) begin
			sel[0] = 1'b1;
			ox     = work_q.dx;
			oy     = work_q.dy;
		end else if (mask_q[1]) begin
			sel[1] = 1'b1;
			kind   = work_q.old[0] ? KIND_RELEASE : KIND_PRESS;
			bnum   = 2'd1;
		end else if (mask_q[2]) begin
			sel[2] = 1'b1;
			kind   = work_q.old[1] ? KIND_RELEASE : KIND_PRESS;
			bnum   = 2'd2;
		end else if (mask_q[3]) begin
			sel[3] = 1'b1;
			kind   = work_q.old[2] ? KIND_RELEASE : KIND_PRESS;
			bnum   = 2'd3;
		end else begin
			sel = '0;
		end
	end

	assign rest = mask_q & ~sel;
	assign last = (rest == '0);
	assign emit = (mask_q != '0) && (!ov_q || m_tready);
	assign pop  = not_empty && ((mask_q == '0) || (emit && last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (pop)
				mask_q <= {head.chg, head.mv};
			else if (emit)
				mask_q <= rest;
			if (emit)
				ov_q <= 1'b1;
			else if (m_tready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			work_q <= head;
		if (emit) begin
			okind_q <= kind;
			ox_q    <= ox;
			oy_q    <= oy;
			obn_q   <= bnum;
			olast_q <= last;
		end
	end

	assign m_tvalid = ov_q;
	assign m_tuser  = okind_q;
	assign m_tlast  = olast_q;
	assign m_tdata  = {{(OUT_TDATA_W - 18){1'b0}}, obn_q, oy_q, ox_q};

endmodule

>>> rtl/ps2_mouse_packet_decoder_top.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_decoder_top
// Three-byte PS/2 mouse packet decoder producing move and button events.
// ----------------------------------------------------------------------------
// Bytes enter on the slave stream with the aux flag in tuser; bytes without
// the flag are dropped. One byte is taken per cycle while the packet queue
// has room. Each completed packet yields 0 to 4 events (move first, then
// left, right, middle button changes), emitted one per cycle by the event
// emitter while the receiver is ready; tlast marks the final event of a
// packet.
module ps2_mouse_packet_decoder_top #(
	parameter int unsigned QUEUE_DEPTH = pmd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // data_byte
	input  logic                            s_tuser,   // aux_data_ready
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [pmd_pkg::OUT_TDATA_W-1:0] m_tdata,   // move_x, move_y, button_number
	output logic [1:0]                      m_tuser,   // event_kind
	output logic                            m_tlast    // last_event
);
	import pmd_pkg::*;

	logic     push;
	logic     full;
	logic     pop;
	logic     not_empty;
	pmd_pkt_t push_pkt;
	pmd_pkt_t head;

	pmd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (full),
		.push     (push),
		.push_pkt (push_pkt)
	);

	pmd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_pkt  (push_pkt),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	pmd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.head      (head),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

>>> dv/ps2_mouse_packet_decoder_checker.sv
// ----------------------------------------------------------------------------
// pmd_event_checker
// Watches both streams of the mouse packet decoder, works out the events each
// accepted aux byte should cause and compares every emitted event with them.
// ----------------------------------------------------------------------------
module pmd_event_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // data_byte
	input  logic                            s_tuser,   // aux_data_ready
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [pmd_pkg::OUT_TDATA_W-1:0] m_tdata,   // move_x, move_y, button_number
	input  logic [1:0]                      m_tuser,   // event_kind
	input  logic                            m_tlast,   // last_event
	output int                              fail_count,
	output int                              events_waiting,
	output int                              events_seen,
	output int                              packets_done
);
	timeunit 1ns;
	timeprecision 1ps;
	import pmd_pkg::*;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] mx;
		logic [7:0] my;
		logic [1:0] button;
		logic       last;
	} mouse_event_t;

	mouse_event_t pending_events[$];
	logic [1:0]   pkt_pos;
	logic [7:0]   pkt_bytes [2];
	logic [2:0]   held_buttons;
	int           n_fail = 0;
	int           n_waiting = 0;
	int           n_seen = 0;
	int           n_packets = 0;

	assign fail_count     = n_fail;
	assign events_waiting = n_waiting;
	assign events_seen    = n_seen;
	assign packets_done   = n_packets;

	task automatic report_fail(input string msg);
		$display("[%0t] %s", $time, msg);
		n_fail++;
	endtask

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		report_fail($sformatf("mismatch on %s: got %02h, expected %02h", what, got, want));
	endtask

	task automatic decode_mouse_byte(input logic [7:0] b);
		mouse_event_t ev;
		logic [2:0]   now;
		int           first;
		if (pkt_pos < LAST_POS) begin
			pkt_bytes[pkt_pos[0]] = b;
			pkt_pos = pkt_pos + 2'd1;
		end else begin
			// third byte (or the unreachable position 3) closes the packet
			pkt_pos = 2'd0;
			now = pkt_bytes[0][2:0];
			first = pending_events.size();
			n_packets++;
			if (pkt_bytes[1] != 8'h00 || b != 8'h00) begin
				ev = '0;
				ev.kind = KIND_MOVE;
				ev.mx = pkt_bytes[1];
				ev.my = b;
				pending_events.push_back(ev);
			end
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				if (now[i] != held_buttons[i]) begin
					ev = '0;
					ev.kind = held_buttons[i] ? KIND_RELEASE : KIND_PRESS;
					ev.button = 2'(i + 1);
					pending_events.push_back(ev);
				end
			end
			held_buttons = now;
			if (pending_events.size() > first)
				pending_events[pending_events.size() - 1].last = 1'b1;
		end
	endtask

	task automatic check_event();
		mouse_event_t want;
		n_seen++;
		if (pending_events.size() == 0) begin
			report_fail($sformatf("unexpected event: kind %0d data %06h last %0b",
				m_tuser, m_tdata, m_tlast));
		end else begin
			want = pending_events.pop_front();
			if (m_tuser !== want.kind)
				report_mismatch("event_kind", 8'(m_tuser), 8'(want.kind));
			if (m_tdata[7:0] !== want.mx)
				report_mismatch("move_x", m_tdata[7:0], want.mx);
			if (m_tdata[15:8] !== want.my)
				report_mismatch("move_y", m_tdata[15:8], want.my);
			if (m_tdata[17:16] !== want.button)
				report_mismatch("button_number", 8'(m_tdata[17:16]), 8'(want.button));
			if (m_tdata[23:18] !== 6'd0)
				report_mismatch("tdata padding", 8'(m_tdata[23:18]), 8'h00);
			if (m_tlast !== want.last)
				report_mismatch("last_event", 8'(m_tlast), 8'(want.last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_pos = 2'd0;
			held_buttons = 3'd0;
			pending_events.delete();
		end else begin
			if (s_tvalid && s_tready && s_tuser)
				decode_mouse_byte(s_tdata);
			if (m_tvalid && m_tready)
				check_event();
		end
		n_waiting = pending_events.size();
	end

endmodule

>>> dv/tb_ps2_mouse_packet_decoder_top.sv
// ----------------------------------------------------------------------------
// tb_ps2_mouse_packet_decoder_top
// Drives aux and non-aux bytes into the mouse packet decoder under several
// idle/stall mixes plus a long output hold-off; the checker scores events.
// ----------------------------------------------------------------------------
module tb_ps2_mouse_packet_decoder_top;
	timeunit 1ns;
	timeprecision 1ps;
	import pmd_pkg::*;

	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_LIMIT  = 20000;
	localparam int SETTLE       = 20;
	localparam int PHASE_PKTS   = 29;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [7:0]             s_tdata = 8'h00;
	logic                   s_tuser = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [1:0]             m_tuser;
	logic                   m_tlast;

	int fail_count;
	int events_waiting;
	int events_seen;
	int packets_done;

	int   snd_idle_pct = 0;
	int   rcv_stall_pct = 0;
	bit   hold_req = 1'b0;
	int   n_sent = 0;
	logic [2:0] last_btns = 3'd0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	ps2_mouse_packet_decoder_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	pmd_event_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.m_tlast        (m_tlast),
		.fail_count     (fail_count),
		.events_waiting (events_waiting),
		.events_seen    (events_seen),
		.packets_done   (packets_done)
	);

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_tready <= ($urandom_range(99) >= rcv_stall_pct);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("timeout");
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic send_byte(input logic aux, input logic [7:0] b);
		while ($urandom_range(99) < snd_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= aux;
		do @(posedge clk); while (!s_tready);
		if (aux)
			n_sent++;
	endtask

	task automatic send_packet(input logic [7:0] b0, input logic [7:0] dx,
			input logic [7:0] dy);
		send_byte(1'b1, b0);
		send_byte(1'b1, dx);
		send_byte(1'b1, dy);
	endtask

	function automatic logic [7:0] pick_motion();
		case ($urandom_range(7))
			0, 1: return 8'h00;
			2: return 8'h7F;
			3: return 8'h80;
			4: return ($urandom_range(1) != 0) ? 8'hFF : 8'h01;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic random_traffic(input int n_pkts);
		logic [7:0] b0;
		for (int k = 0; k < n_pkts; k++) begin
			if ($urandom_range(9) == 0)
				send_byte(1'b0, 8'($urandom));
			if ($urandom_range(24) == 0)
				send_byte(1'b1, 8'($urandom));  // stray byte, breaks framing
			b0 = 8'($urandom);
			if ($urandom_range(1) != 0)
				b0[2:0] = last_btns;
			last_btns = b0[2:0];
			send_packet(b0, pick_motion(), pick_motion());
		end
	endtask

	initial begin
		int wait_cycles;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		send_byte(1'b0, 8'hFF);
		send_packet(8'h00, 8'h00, 8'h00);
		send_packet(8'h07, 8'h7F, 8'h80);
		send_byte(1'b1, 8'hFF);
		send_byte(1'b0, 8'h55);
		send_byte(1'b1, 8'h80);
		send_byte(1'b1, 8'h7F);
		send_packet(8'h00, 8'h00, 8'h01);
		send_packet(8'h02, 8'h00, 8'h00);
		send_packet(8'hF8, 8'hFF, 8'h00);
		send_packet(8'h05, 8'h01, 8'hFF);
		last_btns = 3'd5;

		random_traffic(PHASE_PKTS);
		snd_idle_pct = 87;
		random_traffic(PHASE_PKTS);
		snd_idle_pct = 0;
		rcv_stall_pct = 87;
		random_traffic(PHASE_PKTS);
		snd_idle_pct = 36;
		rcv_stall_pct = 36;
		random_traffic(PHASE_PKTS);
		snd_idle_pct = 0;
		rcv_stall_pct = 0;
		hold_req = 1'b1;
		random_traffic(PHASE_PKTS);

		s_tvalid <= 1'b0;
		wait_cycles = 0;
		while (events_waiting != 0 && wait_cycles < DRAIN_LIMIT) begin
			@(posedge clk);
			wait_cycles++;
		end
		if (wait_cycles >= DRAIN_LIMIT) begin
			$display("timeout waiting for %0d events", events_waiting);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			repeat (SETTLE) @(posedge clk);
			$display("run: %0d aux bytes, %0d packets closed, %0d events checked",
				n_sent, packets_done, events_seen);
			$display("traffic mixes: free-running, sender gaps, receiver stalls, both, hold-off");
			if (fail_count == 0) begin
				$display("ALL CHECKS PASSED");
			end else begin
				$display("%0d mismatches", fail_count);
				$display("CHECKS FAILED");
			end
			$finish;
		end
	end

endmodule
